/* src/fdf_pkg.sv */
package fdf_pkg;

	localparam int unsigned HDR_SIZE       = 16;
	localparam int unsigned CHUNK_HDR_SIZE = 5;
	localparam logic [7:0]  PROTO_VERSION  = 8'd1;
	localparam logic [31:0] MAX_MSG_RESET  = 32'd104857600;

	// configuration register indexes
	localparam logic CFG_MAX_BYTES = 1'b0;
	localparam logic CFG_PRI_NONE  = 1'b1;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_LENGTH  = 2'd1;
	localparam logic [1:0] ERR_VERSION = 2'd2;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  chunk_tag;
		logic [7:0]  data_byte;
		logic        chunk_last;
		logic        message_end;
		logic [7:0]  message_tag;
		logic [7:0]  message_priority;
		logic [31:0] time_seconds;
		logic [31:0] time_micros;
		logic [1:0]  error_code;
	} result_t;

endpackage

/* src/fdf_front.sv */
module fdf_front import fdf_pkg::*; #(
	parameter int unsigned LENGTH_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [7:0]  in_byte,
	input  logic        space,
	output logic        in_ready,
	input  logic        cfg_valid,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output logic        push,
	output result_t     res
);

	localparam logic [32:0] MASK = (33'd1 << LENGTH_BITS) - 33'd1;

	logic [31:0]            max_q;
	logic [7:0]             none_q;
	logic [7:0]             hb_q [HDR_SIZE-1];
	logic [3:0]             hc_q;
	logic                   inpay_q;
	logic [LENGTH_BITS-1:0] total_q;
	logic [31:0]            frem_q;
	logic                   more_q;
	logic [7:0]             ver_q, tag_q, pri_q;
	logic [31:0]            sec_q, us_q;
	logic [2:0]             chp_q;
	logic [7:0]             ctag_q;
	logic [31:0]            crem_q;

	logic [3:0]             hc_d;
	logic                   inpay_d, more_d, clear;
	logic [LENGTH_BITS-1:0] total_d;
	logic [31:0]            frem_d, sec_d, us_d, crem_d, frag, fr_dec;
	logic [7:0]             ver_d, tag_d, pri_d, ctag_d;
	logic [2:0]             chp_d;
	logic [32:0]            sum, sum_hm;
	logic                   first, lenerr, take;

	assign in_ready = space;
	assign take     = in_valid && space;

	always_comb begin
		hc_d    = hc_q;
		inpay_d = inpay_q;
		more_d  = more_q;
		total_d = total_q;
		frem_d  = frem_q;
		ver_d   = ver_q;
		tag_d   = tag_q;
		pri_d   = pri_q;
		sec_d   = sec_q;
		us_d    = us_q;
		chp_d   = chp_q;
		ctag_d  = ctag_q;
		crem_d  = crem_q;
		clear   = 1'b0;
		push    = 1'b0;
		frag    = {hb_q[4], hb_q[5], hb_q[6], hb_q[7]};
		first   = (total_q == '0);
		sum     = 33'(total_q) + {1'b0, frag};
		sum_hm  = (sum + 33'(HDR_SIZE)) & MASK;
		lenerr  = (frag == '0) || (sum > MASK) || (sum >= {1'b0, max_q})
			|| (sum_hm <= 33'(total_q));
		fr_dec  = frem_q - 32'd1;
		res     = '0;

		if (!inpay_q) begin
			hc_d = hc_q + 4'd1;
			if (hc_q == 4'(HDR_SIZE - 1)) begin
				hc_d = '0;
				if (first) begin
					ver_d = hb_q[0];
					tag_d = hb_q[1];
					sec_d = {hb_q[8], hb_q[9], hb_q[10], hb_q[11]};
					us_d  = {hb_q[12], hb_q[13], hb_q[14], in_byte};
				end
				if (pri_q == none_q)
					pri_d = hb_q[2];
				more_d  = (hb_q[3] != 8'd0);
				total_d = sum[LENGTH_BITS-1:0];
				frem_d  = frag;
				inpay_d = 1'b1;
				if (lenerr || ver_d != PROTO_VERSION) begin
					push            = 1'b1;
					clear           = 1'b1;
					res.result_kind = KIND_ERROR;
					res.message_end = 1'b1;
					res.error_code  = lenerr ? ERR_LENGTH : ERR_VERSION;
				end
			end
		end else begin
			frem_d = fr_dec;
			if (chp_q == 3'd0 && crem_q != '0) begin
				crem_d          = crem_q - 32'd1;
				push            = 1'b1;
				res.result_kind = KIND_DATA;
				res.data_byte   = in_byte;
				res.chunk_last  = (crem_q == 32'd1);
			end else begin
				if (chp_q == 3'd0) begin
					ctag_d = in_byte;
					crem_d = '0;
				end else begin
					crem_d = {crem_q[23:0], in_byte};
				end
				chp_d = chp_q + 3'd1;
				if (chp_d == 3'(CHUNK_HDR_SIZE)) begin
					chp_d = '0;
					if (crem_d == '0) begin
						push            = 1'b1;
						res.result_kind = KIND_EMPTY;
						res.chunk_last  = 1'b1;
					end
				end
			end
			res.chunk_tag = ctag_d;
			if (fr_dec == '0) begin
				if (more_q) begin
					inpay_d = 1'b0;
					hc_d    = '0;
				end else begin
					push  = 1'b1;
					clear = 1'b1;
					res.message_end = 1'b1;
					if (chp_d != '0 || crem_d != '0) begin
						res.result_kind = KIND_ERROR;
						res.chunk_tag   = '0;
						res.data_byte   = '0;
						res.chunk_last  = 1'b0;
						res.error_code  = ERR_LENGTH;
					end
				end
			end
		end
		res.message_tag      = tag_d;
		res.message_priority = pri_d;
		res.time_seconds     = sec_d;
		res.time_micros      = us_d;
		push = push && take;
	end

	always_ff @(posedge clk) begin
		if (take && !inpay_q && hc_q != 4'(HDR_SIZE - 1))
			hb_q[hc_q] <= in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= MAX_MSG_RESET;
			none_q  <= '0;
			hc_q    <= '0;
			inpay_q <= 1'b0;
			total_q <= '0;
			frem_q  <= '0;
			more_q  <= 1'b0;
			ver_q   <= '0;
			tag_q   <= '0;
			pri_q   <= '0;
			sec_q   <= '0;
			us_q    <= '0;
			chp_q   <= '0;
			ctag_q  <= '0;
			crem_q  <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_MAX_BYTES: max_q  <= cfg_data;
					CFG_PRI_NONE:  none_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (take) begin
				if (clear) begin
					hc_q    <= '0;
					inpay_q <= 1'b0;
					total_q <= '0;
					frem_q  <= '0;
					more_q  <= 1'b0;
					ver_q   <= '0;
					tag_q   <= '0;
					pri_q   <= none_q;
					sec_q   <= '0;
					us_q    <= '0;
					chp_q   <= '0;
					ctag_q  <= '0;
					crem_q  <= '0;
				end else begin
					hc_q    <= hc_d;
					inpay_q <= inpay_d;
					total_q <= total_d;
					frem_q  <= frem_d;
					more_q  <= more_d;
					ver_q   <= ver_d;
					tag_q   <= tag_d;
					pri_q   <= pri_d;
					sec_q   <= sec_d;
					us_q    <= us_d;
					chp_q   <= chp_d;
					ctag_q  <= ctag_d;
					crem_q  <= crem_d;
				end
			end
		end
	end

	a_err_ends: assert property (@(posedge clk) disable iff (!arst_n)
		push && res.result_kind == KIND_ERROR |-> res.message_end)
		else $error("error result without message end");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> space)
		else $error("result pushed into full queue");
	a_chp_range: assert property (@(posedge clk) disable iff (!arst_n)
		chp_q < 3'(CHUNK_HDR_SIZE))
		else $error("chunk header position out of range");
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take && clear |=> !inpay_q && hc_q == '0)
		else $error("message state not cleared");

endmodule

/* src/fdf_fifo.sv */
module fdf_fifo import fdf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t wdata,
	output logic    space,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t rdata
);

	result_t    mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign space     = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign rdata     = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("queue count overflow");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> (wp_q != rp_q))
		else $error("queue pointers disagree with count");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rp_q))
		else $error("stalled result lost");

endmodule

/* src/fragmented_message_deframer_core.sv */
// Fragmented message deframer.
// Input: one received byte per transaction on s_axis. Fragments of a
// message are a 16-byte header followed by payload; the joined payload is
// a run of chunks (tag byte, 4-byte big-endian length, data).
// Output: m_axis carries at most one result per input byte: a chunk data
// byte, an empty-chunk marker or an error. tlast marks the result that ends
// the message (completion or error); tuser holds the result kind.
// cfg: register 0 is the maximum message size, register 1 the priority
// code meaning unset; write only while the block is idle.
// Throughput: one byte per cycle while the result queue has space. A
// result is registered in the queue before it shows on m_axis. The byte
// parser updates its counters on each taken byte; a two-entry result
// queue parts it from the output. When the receiver stalls, the queue
// fills and s_axis_tready drops once two results are waiting.
// Reset clears all message state and loads register defaults (size limit
// 104857600, unset priority 0); no clearing pass is needed.
module fragmented_message_deframer_core import fdf_pkg::*; #(
	parameter int unsigned LENGTH_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // rx_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// chunk_tag, data_byte, chunk_last, message_tag, message_priority,
	// time_seconds, time_micros, error_code, zero fill
	output logic [103:0] m_axis_tdata,
	output logic         m_axis_tlast,   // message_end
	output logic [1:0]   m_axis_tuser,   // result_kind
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);

	result_t res, qres;
	logic    push, space;

	assign cfg_ready = 1'b1;

	fdf_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_byte   (s_axis_tdata),
		.space     (space),
		.in_ready  (s_axis_tready),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.res       (res)
	);

	fdf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (res),
		.space     (space),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.rdata     (qres)
	);

	assign m_axis_tuser = qres.result_kind;
	assign m_axis_tlast = qres.message_end;
	assign m_axis_tdata = {5'd0, qres.error_code, qres.time_micros, qres.time_seconds,
		qres.message_priority, qres.message_tag, qres.chunk_last, qres.data_byte,
		qres.chunk_tag};

endmodule
